/* hdl/assert_macros.svh */
// assertion macros for the top level rtl, clocked on clock and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ipv4hpc_pkg.sv */
// shared types and constants for the ipv4 header parse and check block
`default_nettype none

package ipv4hpc_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_MALFORMED   = 3'd1,
      ST_CSUM_BAD    = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_FRAGMENT    = 3'd4
   } status_type;

   localparam logic [3:0]  HDR_MIN_WORDS    = 4'd5;
   localparam logic [3:0]  IP_VERSION_4     = 4'd4;
   localparam logic [15:0] HDR_FIXED_OCTETS = 16'd20;
   localparam logic [15:0] COUNT_MAX        = 16'hffff;

   // octet positions in the fixed header
   localparam logic [15:0] OFS_VER_IHL  = 16'd0;
   localparam logic [15:0] OFS_TOS      = 16'd1;
   localparam logic [15:0] OFS_LEN_END  = 16'd4;
   localparam logic [15:0] OFS_ID_END   = 16'd6;
   localparam logic [15:0] OFS_FRAG_END = 16'd8;
   localparam logic [15:0] OFS_TTL      = 16'd8;
   localparam logic [15:0] OFS_PROTO    = 16'd9;
   localparam logic [15:0] OFS_CSUM_END = 16'd12;
   localparam logic [15:0] OFS_SRC_END  = 16'd16;
   localparam logic [15:0] OFS_DST_END  = 16'd20;
   localparam logic [15:0] OFS_CSUM_LO  = 16'd11;

   // captured header and running sum for one datagram
   typedef struct packed {
      logic [15:0] byte_count;
      logic [7:0]  first_octet;
      logic [7:0]  service_octet;
      logic [15:0] length_word;
      logic [15:0] ident_word;
      logic [15:0] flag_offset_word;
      logic [7:0]  ttl_octet;
      logic [7:0]  protocol_octet;
      logic [15:0] received_checksum;
      logic [31:0] source_word;
      logic [31:0] destination_word;
      logic [20:0] sum_accumulator;
   } hdr_state_type;

   // decoded result beat
   typedef struct packed {
      status_type  status;
      logic [3:0]  version;
      logic [3:0]  header_length;
      logic [7:0]  tos;
      logic [15:0] dgram_length;
      logic [15:0] identification;
      logic [2:0]  flags;
      logic [12:0] frag_offset;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
   } result_type;

endpackage

`default_nettype wire

/* hdl/ipv4hpc_accum.sv */
// header field capture and ones' complement word sum, one octet per cycle while advance is high
`default_nettype none

module ipv4hpc_accum
   import ipv4hpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic [7:0]    data_byte,
   input  wire logic          last_byte,
   output hdr_state_type      state_next,
   output logic [15:0]        count_now
);

   hdr_state_type state_ff;
   hdr_state_type state_in;
   logic [7:0]    held_ff;
   logic [7:0]    held_in;
   logic [15:0]   pos;
   logic [3:0]    ihl;
   logic          in_hdr;

   assign pos       = state_ff.byte_count;
   assign count_now = state_ff.byte_count;

   // capture fields by position and fold header words into the sum
   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      ihl      = (pos == OFS_VER_IHL) ? data_byte[3:0] : state_ff.first_octet[3:0];
      in_hdr   = pos < {10'd0, ihl, 2'b00};

      if (pos == OFS_VER_IHL) begin
         state_in.first_octet = data_byte;
      end else if (pos == OFS_TOS) begin
         state_in.service_octet = data_byte;
      end else if (pos < OFS_LEN_END) begin
         state_in.length_word = {state_ff.length_word[7:0], data_byte};
      end else if (pos < OFS_ID_END) begin
         state_in.ident_word = {state_ff.ident_word[7:0], data_byte};
      end else if (pos < OFS_FRAG_END) begin
         state_in.flag_offset_word = {state_ff.flag_offset_word[7:0], data_byte};
      end else if (pos == OFS_TTL) begin
         state_in.ttl_octet = data_byte;
      end else if (pos == OFS_PROTO) begin
         state_in.protocol_octet = data_byte;
      end else if (pos < OFS_CSUM_END) begin
         state_in.received_checksum = {state_ff.received_checksum[7:0], data_byte};
      end else if (pos < OFS_SRC_END) begin
         state_in.source_word = {state_ff.source_word[23:0], data_byte};
      end else if (pos < OFS_DST_END) begin
         state_in.destination_word = {state_ff.destination_word[23:0], data_byte};
      end

      // even octet waits for its partner, checksum word counts as zero
      if (in_hdr) begin
         if (!pos[0]) begin
            held_in = data_byte;
         end else if (pos != OFS_CSUM_LO) begin
            state_in.sum_accumulator = state_ff.sum_accumulator + {5'd0, held_ff, data_byte};
         end
      end

      // saturating octet count
      if (pos != COUNT_MAX) begin
         state_in.byte_count = pos + 16'd1;
      end
   end

   assign state_next = state_in;

   // state clears after the final octet so the next datagram starts clean
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         held_ff  <= '0;
      end else if (advance) begin
         if (last_byte) begin
            state_ff <= '0;
            held_ff  <= '0;
         end else begin
            state_ff <= state_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/ipv4hpc_check.sv */
// header checks and field decode on a finished datagram
`default_nettype none

module ipv4hpc_check
   import ipv4hpc_pkg::*;
(
   input  wire hdr_state_type hdr,
   output result_type         result
);

   logic [3:0]  ver;
   logic [3:0]  ihl;
   logic [15:0] hdr_octets;
   logic [15:0] tlen;
   logic [2:0]  flag_bits;
   logic [12:0] foff;
   logic [16:0] fold_one;
   logic [15:0] fold_two;
   logic [15:0] calc;
   status_type  status;

   assign ver        = hdr.first_octet[7:4];
   assign ihl        = hdr.first_octet[3:0];
   assign hdr_octets = {10'd0, ihl, 2'b00};
   assign tlen       = hdr.length_word;
   assign flag_bits  = hdr.flag_offset_word[15:13];
   assign foff       = hdr.flag_offset_word[12:0];

   // fold the carries back in twice, then complement
   assign fold_one = {1'b0, hdr.sum_accumulator[15:0]} + {12'd0, hdr.sum_accumulator[20:16]};
   assign fold_two = fold_one[15:0] + {15'd0, fold_one[16]};
   assign calc     = ~fold_two;

   // first failing check sets the status
   always_comb begin
      if (ihl < HDR_MIN_WORDS) begin
         status = ST_MALFORMED;
      end else if (hdr.byte_count < hdr_octets || hdr.byte_count < tlen) begin
         status = ST_MALFORMED;
      end else if (tlen < hdr_octets) begin
         status = ST_MALFORMED;
      end else if (flag_bits[2]) begin
         status = ST_MALFORMED;
      end else if (calc != hdr.received_checksum) begin
         status = ST_CSUM_BAD;
      end else if (ver != IP_VERSION_4 || ihl > HDR_MIN_WORDS) begin
         status = ST_UNSUPPORTED;
      end else if (flag_bits[0] || foff != 13'd0) begin
         status = ST_FRAGMENT;
      end else begin
         status = ST_OK;
      end
   end

   // short datagram reports malformed with every field zero
   always_comb begin
      if (hdr.byte_count < HDR_FIXED_OCTETS) begin
         result        = '0;
         result.status = ST_MALFORMED;
      end else begin
         result.status         = status;
         result.version        = ver;
         result.header_length  = ihl;
         result.tos            = hdr.service_octet;
         result.dgram_length   = tlen;
         result.identification = hdr.ident_word;
         result.flags          = flag_bits;
         result.frag_offset    = foff;
         result.ttl            = hdr.ttl_octet;
         result.protocol       = hdr.protocol_octet;
         result.src_addr       = hdr.source_word;
         result.dst_addr       = hdr.destination_word;
      end
   end

endmodule

`default_nettype wire

/* hdl/ipv4_header_parse_check.sv */
// top level of the ipv4 header parse and check block
//
// The req channel takes a received datagram one octet per beat, with
// req_last_byte high on the final octet. The rsp channel gives one beat per
// datagram: a status and the decoded header fields.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// Throughput is one octet per cycle while req_stall is low: each octet needs a
// capture and at most one word add into the sum in the accumulate stage.
// Pipeline: input register, accumulate/snapshot register, check and result
// register. The result beat passes the snapshot and result registers after the
// final octet's beat is taken and holds until it is taken.
// When rsp_stall holds a result, octets that are not final keep flowing;
// a final octet waits in the input register only while both the snapshot
// and the result registers are full, and req_stall rises then.
// Synchronous reset clears all valid flags and the captured header state;
// the block takes octets the cycle after reset falls.
`default_nettype none

module ipv4_header_parse_check
   import ipv4hpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_version,
   output logic [3:0]       rsp_header_length,
   output logic [7:0]       rsp_tos,
   output logic [15:0]      rsp_dgram_length,
   output logic [15:0]      rsp_identification,
   output logic [2:0]       rsp_flags,
   output logic [12:0]      rsp_frag_offset,
   output logic [7:0]       rsp_ttl,
   output logic [7:0]       rsp_protocol,
   output logic [31:0]      rsp_src_addr,
   output logic [31:0]      rsp_dst_addr
);

`include "assert_macros.svh"

   logic          in_vld_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   logic          in_adv;
   logic          in_ready;
   hdr_state_type snap_ff;
   logic          snap_vld_ff;
   logic          snap_ready;
   hdr_state_type state_next;
   logic [15:0]   count_now;
   result_type    res_ff;
   result_type    res_in;
   logic          res_vld_ff;
   logic          res_ready;

   // backpressure chain from the rsp side
   assign res_ready  = !res_vld_ff || !rsp_stall;
   assign snap_ready = !snap_vld_ff || res_ready;
   assign in_adv     = in_vld_ff && (!in_last_ff || snap_ready);
   assign in_ready   = !in_vld_ff || in_adv;
   assign req_stall  = !in_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   ipv4hpc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .advance    (in_adv),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_next (state_next),
      .count_now  (count_now)
   );

   // snapshot of a finished datagram
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= 1'b0;
      end else if (snap_ready) begin
         snap_vld_ff <= in_adv && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready && in_adv && in_last_ff) begin
         snap_ff <= state_next;
      end
   end

   ipv4hpc_check u_check (
      .hdr    (snap_ff),
      .result (res_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else if (res_ready) begin
         res_vld_ff <= snap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && snap_vld_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid          = res_vld_ff;
   assign rsp_status         = res_ff.status;
   assign rsp_version        = res_ff.version;
   assign rsp_header_length  = res_ff.header_length;
   assign rsp_tos            = res_ff.tos;
   assign rsp_dgram_length   = res_ff.dgram_length;
   assign rsp_identification = res_ff.identification;
   assign rsp_flags          = res_ff.flags;
   assign rsp_frag_offset    = res_ff.frag_offset;
   assign rsp_ttl            = res_ff.ttl;
   assign rsp_protocol       = res_ff.protocol;
   assign rsp_src_addr       = res_ff.src_addr;
   assign rsp_dst_addr       = res_ff.dst_addr;

   // checks
   `ASSERT_IMPLY(a_stall_only_on_final, req_stall, in_vld_ff && in_last_ff, "stall without held final octet")
   `ASSERT_IMPLY(a_snap_count_nonzero, snap_vld_ff, snap_ff.byte_count != 16'd0, "finished datagram with zero octets")
   `ASSERT_NEXT(a_final_clears_count, in_adv && in_last_ff, count_now == 16'd0, "octet count not cleared after final octet")
   `ASSERT_NEXT(a_short_is_malformed, snap_vld_ff && res_ready && snap_ff.byte_count < HDR_FIXED_OCTETS, rsp_status == ST_MALFORMED && rsp_src_addr == 32'd0, "short datagram not reported malformed")

endmodule

`default_nettype wire

/* sim/tb_ipv4_header_parse_check.sv */
// self-checking testbench for the ipv4 header parse and check block
module tb_ipv4_header_parse_check;
   timeunit 1ns;
   timeprecision 1ps;
   import ipv4hpc_pkg::*;

   localparam int unsigned RANDOM_OCTETS = 1015;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned HOLD_AFTER    = 25;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES  = 10;

   // flag bit positions within the three-bit flags field
   localparam int FLAG_RESERVED = 2;
   localparam int FLAG_MORE     = 0;

   // one datagram to send: header fields, octets on the wire, checksum damage
   typedef struct packed {
      logic [7:0]  ver_ihl;
      logic [7:0]  tos;
      logic [15:0] tlen;
      logic [15:0] ident;
      logic [15:0] flag_off;
      logic [7:0]  ttl;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [16:0] octets;
      logic [15:0] csum_flip;
      logic        typed;
      status_type  want;
   } datagram_row_type;

   typedef struct packed {
      logic       known;
      result_type value;
   } typed_result_type;

   localparam int DIRECTED_ROWS = 22;

   // ver_ihl tos tlen ident flag_off ttl proto src dst octets csum_flip typed want
   localparam datagram_row_type DIRECTED [DIRECTED_ROWS] = '{
      // lone octet marked last
      '{8'h45, 8'h00, 16'd20, 16'h0000, 16'h0000, 8'h40, 8'h06, 32'h0a000001,
        32'h0a000002, 17'd1, 16'h0000, 1'b1, ST_MALFORMED},
      // one octet short of a header
      '{8'h45, 8'h00, 16'd20, 16'h0001, 16'h0000, 8'h40, 8'h06, 32'h0a000001,
        32'h0a000002, 17'd19, 16'h0000, 1'b1, ST_MALFORMED},
      // minimal clean header
      '{8'h45, 8'h00, 16'd20, 16'h1234, 16'h0000, 8'h40, 8'h11, 32'hc0a80001,
        32'hc0a80002, 17'd20, 16'h0000, 1'b1, ST_OK},
      // fields at top of range
      '{8'h45, 8'hff, 16'd20, 16'hffff, 16'h4000, 8'hff, 8'hff, 32'hffffffff,
        32'hffffffff, 17'd20, 16'h0000, 1'b1, ST_OK},
      // fields at zero
      '{8'h45, 8'h00, 16'd20, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'h00000000,
        32'h00000000, 17'd20, 16'h0000, 1'b1, ST_OK},
      // ihl zero
      '{8'h40, 8'h00, 16'd20, 16'h0002, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_MALFORMED},
      // ihl four
      '{8'h44, 8'h00, 16'd20, 16'h0003, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_MALFORMED},
      // cut short against total length
      '{8'h45, 8'h10, 16'd40, 16'h0004, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd30, 16'h0000, 1'b1, ST_MALFORMED},
      // cut short against ihl
      '{8'h4f, 8'h00, 16'd60, 16'h0005, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd40, 16'h0000, 1'b1, ST_MALFORMED},
      // total length under the header
      '{8'h45, 8'h00, 16'd19, 16'h0006, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_MALFORMED},
      // reserved flag
      '{8'h45, 8'h00, 16'd20, 16'h0007, 16'hc000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_MALFORMED},
      // reserved flag wins over a bad checksum
      '{8'h45, 8'h00, 16'd20, 16'h0008, 16'h8000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'hffff, 1'b1, ST_MALFORMED},
      // checksum off by one bit
      '{8'h45, 8'h00, 16'd20, 16'h0009, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0001, 1'b1, ST_CSUM_BAD},
      // checksum checked before version
      '{8'hf5, 8'h00, 16'd20, 16'h000a, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h8000, 1'b1, ST_CSUM_BAD},
      // version six
      '{8'h65, 8'h00, 16'd20, 16'h000b, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_UNSUPPORTED},
      // one option word
      '{8'h46, 8'h00, 16'd24, 16'h000c, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd24, 16'h0000, 1'b1, ST_UNSUPPORTED},
      // largest header
      '{8'h4f, 8'h00, 16'd60, 16'h000d, 16'h0000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd60, 16'h0000, 1'b1, ST_UNSUPPORTED},
      // more fragments
      '{8'h45, 8'h00, 16'd20, 16'h000e, 16'h2000, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_FRAGMENT},
      // largest offset
      '{8'h45, 8'h00, 16'd20, 16'h000f, 16'h1fff, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_FRAGMENT},
      // df, mf and offset together
      '{8'h45, 8'h00, 16'd20, 16'h0010, 16'h7fff, 8'h40, 8'h06, 32'h01020304,
        32'h05060708, 17'd20, 16'h0000, 1'b1, ST_FRAGMENT},
      // payload past the total length
      '{8'h45, 8'h5a, 16'd20, 16'hbeef, 16'h4000, 8'h80, 8'h01, 32'h7f000001,
        32'he0000001, 17'd37, 16'h0000, 1'b0, ST_OK},
      // options with a payload
      '{8'h47, 8'ha5, 16'd44, 16'h5a5a, 16'h0000, 8'h01, 8'h2f, 32'h80808080,
        32'h01010101, 17'd44, 16'h0000, 1'b0, ST_OK}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_version;
   logic [3:0]  rsp_header_length;
   logic [7:0]  rsp_tos;
   logic [15:0] rsp_dgram_length;
   logic [15:0] rsp_identification;
   logic [2:0]  rsp_flags;
   logic [12:0] rsp_frag_offset;
   logic [7:0]  rsp_ttl;
   logic [7:0]  rsp_protocol;
   logic [31:0] rsp_src_addr;
   logic [31:0] rsp_dst_addr;

   // octets to send, last mark on top
   logic [8:0]       octet_stream [$];
   typed_result_type typed_results [$];
   result_type       expected_results [$];

   int unsigned mismatch_count = 0;
   int unsigned results_taken = 0;
   int unsigned octets_taken = 0;
   int unsigned datagrams_queued = 0;
   int unsigned quiet_cycles = 0;
   bit          long_hold_done = 1'b0;

   // header state of the predictor
   logic [15:0] seen_octets;
   logic [7:0]  lead_octet;
   logic [7:0]  tos_octet;
   logic [15:0] len_field;
   logic [15:0] id_field;
   logic [15:0] frag_field;
   logic [7:0]  ttl_octet;
   logic [7:0]  proto_octet;
   logic [15:0] csum_field;
   logic [31:0] src_field;
   logic [31:0] dst_field;
   logic [20:0] word_sum;
   logic [7:0]  pending_high;

   ipv4_header_parse_check uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_version        (rsp_version),
      .rsp_header_length  (rsp_header_length),
      .rsp_tos            (rsp_tos),
      .rsp_dgram_length   (rsp_dgram_length),
      .rsp_identification (rsp_identification),
      .rsp_flags          (rsp_flags),
      .rsp_frag_offset    (rsp_frag_offset),
      .rsp_ttl            (rsp_ttl),
      .rsp_protocol       (rsp_protocol),
      .rsp_src_addr       (rsp_src_addr),
      .rsp_dst_addr       (rsp_dst_addr)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_header_state();
      seen_octets  = '0;
      lead_octet   = '0;
      tos_octet    = '0;
      len_field    = '0;
      id_field     = '0;
      frag_field   = '0;
      ttl_octet    = '0;
      proto_octet  = '0;
      csum_field   = '0;
      src_field    = '0;
      dst_field    = '0;
      word_sum     = '0;
      pending_high = '0;
   endtask

   // predictor: capture one octet, close the datagram on the last mark
   task automatic absorb_octet(input logic [7:0] b, input logic last,
                               output bit closed, output result_type r);
      logic [15:0] pos;
      logic [15:0] count;
      logic [15:0] hdr_octets;
      logic [3:0]  ihl;
      logic [3:0]  ver;
      logic [2:0]  flag_bits;
      logic [12:0] offset;
      logic [16:0] fold;
      logic [15:0] computed;
      pos = seen_octets;
      ihl = (pos == OFS_VER_IHL) ? b[3:0] : lead_octet[3:0];
      // fixed header capture
      if (pos == OFS_VER_IHL) lead_octet = b;
      else if (pos == OFS_TOS) tos_octet = b;
      else if (pos < OFS_LEN_END) len_field = {len_field[7:0], b};
      else if (pos < OFS_ID_END) id_field = {id_field[7:0], b};
      else if (pos < OFS_FRAG_END) frag_field = {frag_field[7:0], b};
      else if (pos == OFS_TTL) ttl_octet = b;
      else if (pos == OFS_PROTO) proto_octet = b;
      else if (pos < OFS_CSUM_END) csum_field = {csum_field[7:0], b};
      else if (pos < OFS_SRC_END) src_field = {src_field[23:0], b};
      else if (pos < OFS_DST_END) dst_field = {dst_field[23:0], b};
      // header words into the sum, checksum word counted as zero
      if (pos < {10'd0, ihl, 2'b00}) begin
         if (!pos[0]) pending_high = b;
         else if (pos != OFS_CSUM_LO) word_sum = word_sum + {5'd0, pending_high, b};
      end
      if (seen_octets != COUNT_MAX) seen_octets = seen_octets + 16'd1;
      closed = last;
      r = '0;
      if (!last) return;

      count      = seen_octets;
      ver        = lead_octet[7:4];
      ihl        = lead_octet[3:0];
      hdr_octets = {10'd0, ihl, 2'b00};
      flag_bits  = frag_field[15:13];
      offset     = frag_field[12:0];
      fold       = {1'b0, word_sum[15:0]} + {12'd0, word_sum[20:16]};
      fold       = {1'b0, fold[15:0]} + {16'd0, fold[16]};
      computed   = ~fold[15:0];
      // checks in priority order, short datagram leaves every field zero
      if (count < HDR_FIXED_OCTETS) begin
         r.status = ST_MALFORMED;
      end else begin
         if (ihl < HDR_MIN_WORDS) r.status = ST_MALFORMED;
         else if (count < hdr_octets || count < len_field) r.status = ST_MALFORMED;
         else if (len_field < hdr_octets) r.status = ST_MALFORMED;
         else if (flag_bits[FLAG_RESERVED]) r.status = ST_MALFORMED;
         else if (computed != csum_field) r.status = ST_CSUM_BAD;
         else if (ver != IP_VERSION_4 || ihl > HDR_MIN_WORDS) r.status = ST_UNSUPPORTED;
         else if (flag_bits[FLAG_MORE] || offset != '0) r.status = ST_FRAGMENT;
         else r.status = ST_OK;
         r.version        = ver;
         r.header_length  = ihl;
         r.tos            = tos_octet;
         r.dgram_length   = len_field;
         r.identification = id_field;
         r.flags          = flag_bits;
         r.frag_offset    = offset;
         r.ttl            = ttl_octet;
         r.protocol       = proto_octet;
         r.src_addr       = src_field;
         r.dst_addr       = dst_field;
      end
      clear_header_state();
   endtask

   // lay out one datagram with its checksum and queue its octets
   task automatic queue_datagram(input datagram_row_type row);
      logic [159:0]     fixed_header;
      logic [7:0]       frame [$];
      logic [31:0]      word_total;
      logic [15:0]      csum;
      int unsigned      i;
      int unsigned      span;
      typed_result_type typed;
      fixed_header = {row.ver_ihl, row.tos, row.tlen, row.ident, row.flag_off, row.ttl,
                      row.proto, 16'h0000, row.src, row.dst};
      for (i = 0; i < row.octets; i++)
         frame.push_back(i < 20 ? fixed_header[159 - 8 * i -: 8] : 8'($urandom));
      // checksum over the header words that actually arrive
      span = row.ver_ihl[3:0] * 4;
      if (span > row.octets) span = row.octets;
      word_total = '0;
      for (i = 0; i + 1 < span; i += 2) word_total += {16'd0, frame[i], frame[i + 1]};
      word_total = word_total[15:0] + word_total[31:16];
      word_total = word_total[15:0] + word_total[31:16];
      csum = ~word_total[15:0] ^ row.csum_flip;
      if (row.octets > 10) frame[10] = csum[15:8];
      if (row.octets > 11) frame[11] = csum[7:0];
      foreach (frame[j]) octet_stream.push_back({j == frame.size() - 1, frame[j]});
      // expectation typed in from the row, when the row carries one
      typed.known = row.typed;
      typed.value = '0;
      typed.value.status = row.want;
      if (row.octets >= 20) begin
         typed.value.version        = row.ver_ihl[7:4];
         typed.value.header_length  = row.ver_ihl[3:0];
         typed.value.tos            = row.tos;
         typed.value.dgram_length   = row.tlen;
         typed.value.identification = row.ident;
         typed.value.flags          = row.flag_off[15:13];
         typed.value.frag_offset    = row.flag_off[12:0];
         typed.value.ttl            = row.ttl;
         typed.value.protocol       = row.proto;
         typed.value.src_addr       = row.src;
         typed.value.dst_addr       = row.dst;
      end
      typed_results.push_back(typed);
      datagrams_queued++;
   endtask

   // random datagram, mostly well formed, the rest broken or noise
   task automatic make_random_row(output datagram_row_type row);
      int unsigned kind;
      int unsigned hdr_octets;
      int unsigned ver;
      logic [3:0]  ihl;
      kind          = $urandom_range(0, 99);
      row.tos       = 8'($urandom);
      row.ident     = 16'($urandom);
      row.ttl       = 8'($urandom);
      row.proto     = 8'($urandom);
      row.src       = $urandom;
      row.dst       = $urandom;
      row.flag_off  = ($urandom_range(0, 1) == 1) ? 16'h4000 : 16'h0000;
      row.csum_flip = '0;
      row.typed     = 1'b0;
      row.want      = ST_OK;
      ihl = HDR_MIN_WORDS;
      if (kind >= 56 && kind < 64) ihl = 4'($urandom_range(6, 15));
      if (kind >= 88 && kind < 91) ihl = 4'($urandom_range(0, 4));
      row.ver_ihl = {IP_VERSION_4, ihl};
      hdr_octets  = (ihl < HDR_MIN_WORDS) ? 20 : ihl * 4;
      row.octets  = 17'(hdr_octets + $urandom_range(0, 12));
      row.tlen    = 16'(row.octets);
      if (kind < 50) begin
         // clean datagram
      end else if (kind < 56) begin
         row.flag_off = {1'b0, 15'($urandom_range(1, 32767))};
      end else if (kind < 64) begin
         // options present
      end else if (kind < 70) begin
         row.csum_flip = 16'($urandom_range(1, 65535));
      end else if (kind < 75) begin
         ver = $urandom_range(0, 14);
         if (ver >= IP_VERSION_4) ver++;
         row.ver_ihl[7:4] = 4'(ver);
      end else if (kind < 80) begin
         row.flag_off = {1'b1, 15'($urandom)};
      end else if (kind < 85) begin
         row.tlen = row.tlen + 16'($urandom_range(1, 40));
      end else if (kind < 88) begin
         row.tlen = 16'($urandom_range(0, hdr_octets - 1));
      end else if (kind < 91) begin
         // ihl below five
      end else if (kind < 95) begin
         row.octets = 17'($urandom_range(1, 19));
      end else begin
         row.ver_ihl   = 8'($urandom);
         row.flag_off  = 16'($urandom);
         row.tlen      = 16'($urandom_range(0, 64));
         row.octets    = 17'($urandom_range(1, 64));
         row.csum_flip = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'h0000;
      end
   endtask

   // idle length: mostly none, some short, a few long
   function automatic int unsigned idle_cycles(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(input string field_name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // sample both channels, predict on octet beats, compare on result beats
   always @(posedge clock) begin : monitor
      result_type       got;
      result_type       want;
      result_type       predicted;
      typed_result_type typed;
      bit               closed;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_version, rsp_header_length, rsp_tos,
                   rsp_dgram_length, rsp_identification, rsp_flags, rsp_frag_offset,
                   rsp_ttl, rsp_protocol, rsp_src_addr, rsp_dst_addr};
            results_taken++;
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected, status 0x%0h", rsp_status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("version", want.version, got.version);
               check_field("header_length", want.header_length, got.header_length);
               check_field("tos", want.tos, got.tos);
               check_field("dgram_length", want.dgram_length, got.dgram_length);
               check_field("identification", want.identification, got.identification);
               check_field("flags", want.flags, got.flags);
               check_field("frag_offset", want.frag_offset, got.frag_offset);
               check_field("ttl", want.ttl, got.ttl);
               check_field("protocol", want.protocol, got.protocol);
               check_field("src_addr", want.src_addr, got.src_addr);
               check_field("dst_addr", want.dst_addr, got.dst_addr);
            end
         end
         if (req_valid && !req_stall) begin
            octets_taken++;
            absorb_octet(req_data_byte, req_last_byte, closed, predicted);
            if (closed) begin
               typed = typed_results.pop_front();
               expected_results.push_back(typed.known ? typed.value : predicted);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_ipv4_header_parse_check: errors");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off once results are flowing
   initial begin : receiver
      int unsigned hold_len;
      int unsigned rounds;
      bit          calm;
      rounds = 0;
      calm   = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rounds % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         rounds++;
         rsp_stall = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         if (!long_hold_done && results_taken >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_len = LONG_HOLD;
         end else begin
            hold_len = idle_cycles(calm);
         end
         if (hold_len != 0) begin
            rsp_stall = 1'b1;
            repeat (hold_len) @(negedge clock);
         end
      end
   end

   // sender: build the stream, reset, then offer every octet
   initial begin : sender
      datagram_row_type row;
      int unsigned      random_start;
      int unsigned      beat;
      int unsigned      gap;
      bit               calm;
      calm = 1'b0;
      clear_header_state();
      for (int k = 0; k < DIRECTED_ROWS; k++) queue_datagram(DIRECTED[k]);
      random_start = octet_stream.size();
      while (octet_stream.size() - random_start < RANDOM_OCTETS) begin
         make_random_row(row);
         queue_datagram(row);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (beat = 0; beat < octet_stream.size(); beat++) begin
         if (beat % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = idle_cycles(calm);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid = 1'b1;
         {req_last_byte, req_data_byte} = octet_stream[beat];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         @(negedge clock);
      end
      req_valid = 1'b0;

      // drain outstanding results, then watch for strays
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d datagrams in %0d octets, %0d results compared",
               datagrams_queued, octets_taken, results_taken);
      $display("directed header cases, random mix, %0d-cycle hold", LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("tb_ipv4_header_parse_check: clean");
      end else begin
         $display("tb_ipv4_header_parse_check: errors");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/ipv4hpc_pkg.sv
hdl/ipv4hpc_accum.sv
hdl/ipv4hpc_check.sv
hdl/ipv4_header_parse_check.sv
sim/tb_ipv4_header_parse_check.sv
